// ===== rtl/rvmx_pkg.sv =====
// Package with the opcodes, status codes, sequencer states and shared types of the executor.
package rvmx_pkg;

    localparam int REG_AW     = 4;
    localparam int CODE_DEPTH = 1024;

    localparam logic [REG_AW-1:0] IP_REG   = 4'd15;
    localparam logic [REG_AW-1:0] LINK_REG = 4'd14;

    localparam logic [4:0] OP_READ = 5'd0;
    localparam logic [4:0] OP_WR   = 5'd1;
    localparam logic [4:0] OP_BEQ  = 5'd2;
    localparam logic [4:0] OP_BLT  = 5'd3;
    localparam logic [4:0] OP_BLE  = 5'd4;
    localparam logic [4:0] OP_BNE  = 5'd5;
    localparam logic [4:0] OP_BGT  = 5'd6;
    localparam logic [4:0] OP_BGE  = 5'd7;
    localparam logic [4:0] OP_BR   = 5'd8;
    localparam logic [4:0] OP_BL   = 5'd9;
    localparam logic [4:0] OP_RET  = 5'd10;
    localparam logic [4:0] OP_MOV  = 5'd11;
    localparam logic [4:0] OP_CMP  = 5'd12;
    localparam logic [4:0] OP_ADD  = 5'd13;
    localparam logic [4:0] OP_SUB  = 5'd14;
    localparam logic [4:0] OP_MUL  = 5'd15;
    localparam logic [4:0] OP_DIV  = 5'd16;
    localparam logic [4:0] OP_MOD  = 5'd17;
    localparam logic [4:0] OP_MOVI = 5'd18;
    localparam logic [4:0] OP_CMPI = 5'd19;
    localparam logic [4:0] OP_ADDI = 5'd20;
    localparam logic [4:0] OP_SUBI = 5'd21;
    localparam logic [4:0] OP_MULI = 5'd22;
    localparam logic [4:0] OP_DIVI = 5'd23;
    localparam logic [4:0] OP_MODI = 5'd24;
    localparam logic [4:0] OP_LD   = 5'd25;
    localparam logic [4:0] OP_ST   = 5'd26;
    localparam logic [4:0] OP_PSH  = 5'd27;
    localparam logic [4:0] OP_POP  = 5'd28;
    localparam logic [4:0] OP_NOP  = 5'd29;
    localparam logic [4:0] OP_HLT  = 5'd30;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_BADOP = 2'd2;
    localparam logic [1:0] ST_BADIP = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RB,
        S_RC,
        S_RA,
        S_CAPA,
        S_CALC,
        S_DIVW,
        S_ADDR,
        S_MODW,
        S_MODR,
        S_MEM,
        S_MWAIT,
        S_WB1,
        S_WB2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/rvmx_regfile.sv =====
// Register file memory with one write and one registered read port and per-entry valid bits.
module rvmx_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rvmx_pkg::REG_AW-1:0] raddr,
    output logic [31:0]                 rdata,
    input  logic                        we,
    input  logic [rvmx_pkg::REG_AW-1:0] waddr,
    input  logic [31:0]                 wdata
);
    import rvmx_pkg::*;

    localparam int DEPTH = 1 << REG_AW;

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      rd_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    // Entries never written since reset read as zero.
    assign rdata = rd_valid_reg ? rd_reg : 32'd0;

endmodule

// ===== rtl/rvmx_dmem.sv =====
// Data memory with a registered read port and a clearing sweep after reset.
module rvmx_dmem #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         busy,
    input  logic                         we,
    input  logic [$clog2(MEM_DEPTH)-1:0] addr,
    input  logic [31:0]                  wdata,
    output logic [31:0]                  rdata
);
    localparam int AW = $clog2(MEM_DEPTH);

    logic [31:0]   mem [MEM_DEPTH];
    logic [31:0]   rd_reg;
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= 32'd0;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
    end

    assign busy  = clearing_reg;
    assign rdata = rd_reg;

endmodule

// ===== rtl/rvmx_divider.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module rvmx_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  rvmx_pkg::div_req_t req,
    output rvmx_pkg::div_rsp_t rsp
);
    import rvmx_pkg::*;

    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            q_reg <= req.num;
            r_reg <= 32'd0;
            d_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

endmodule

// ===== rtl/register_vm_instruction_executor_unit.sv =====
// Top level of the register machine executor: sequencer, ALU and the result register.
// A running step reads its operands one after another through the registered register file port.
// A divide by a non-zero value waits in S_DIVW for the divider, and a memory access passes
// through the reduction states S_MODW and S_MODR when MEM_DEPTH is not a power of two.
// One item at a time: the next beat is taken only after the result is built and the
// sequencer is back in its idle state. Frozen steps go straight to the result state.
// Reset is asynchronous and active low; afterwards the data memory is swept to zero, and
// no beat is accepted during the sweep.
module register_vm_instruction_executor_unit #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [4:0]         req_type,
    input  logic signed [31:0] field_a,
    input  logic signed [31:0] field_b,
    input  logic signed [31:0] field_c,
    input  logic [31:0]        read_value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [31:0]        next_ip,
    output logic               out_valid,
    output logic [31:0]        out_value,
    output logic [1:0]         status
);
    import rvmx_pkg::*;

    localparam int AW   = $clog2(MEM_DEPTH);
    localparam bit POW2 = ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0);
    // Reciprocal of the memory depth in 0.32 fixed point, rounded down.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_DEPTH));

    // Sequencer and item registers.
    state_t        state_reg, state_next;
    logic [4:0]    op_reg, op_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic [31:0]   c_reg, c_next;
    logic [31:0]   rv_reg, rv_next;
    logic [31:0]   va_reg, va_next;
    logic [31:0]   vb_reg, vb_next;
    logic [31:0]   vc_reg, vc_next;
    logic [31:0]   res_reg, res_next;
    logic [31:0]   addr_reg, addr_next;
    logic [AW-1:0] maddr_reg, maddr_next;
    logic [31:0]   mq_reg, mq_next;
    logic [31:0]   mr_reg, mr_next;
    logic [REG_AW-1:0] wa_reg, wa_next;
    logic          wb1_reg, wb1_next;
    logic [31:0]   nip_reg, nip_next;
    logic          run_reg, run_next;
    logic [1:0]    code_reg, code_next;
    logic          ov_reg, ov_next;
    logic [31:0]   oval_reg, oval_next;

    // Architectural state held in flip-flops.
    logic [31:0]   ip_reg, ip_next;
    logic          zf_reg, zf_next;
    logic          nf_reg, nf_next;
    logic [1:0]    stopped_reg, stopped_next;

    // Result register.
    logic          rsp_valid_reg, rsp_valid_next;
    logic [31:0]   rsp_ip_reg, rsp_ip_next;
    logic          rsp_ov_reg, rsp_ov_next;
    logic [31:0]   rsp_oval_reg, rsp_oval_next;
    logic [1:0]    rsp_st_reg, rsp_st_next;

    // Memory and divider connections.
    logic [REG_AW-1:0] rf_raddr;
    logic [31:0]       rf_rdata;
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata;
    logic              dm_busy;
    logic              dm_we;
    logic [AW-1:0]     dm_addr;
    logic [31:0]       dm_wdata;
    logic [31:0]       dm_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [REG_AW-1:0] ra, rb, rc;
    logic [31:0]       y;
    logic [31:0]       prod;
    logic [31:0]       br_target;
    logic              take;
    logic [1:0]        fin_status;
    logic [63:0]       recip_prod;
    logic [31:0]       mr_fix;

    assign ra = a_reg[REG_AW-1:0];
    assign rb = b_reg[REG_AW-1:0];
    assign rc = c_reg[REG_AW-1:0];

    // Register operand or immediate for the arithmetic forms.
    assign y         = (op_reg >= OP_ADDI) ? c_reg : vc_reg;
    assign prod      = vb_reg * y;
    assign br_target = ip_reg + a_reg;

    // Address reduction for a depth that is not a power of two: the reciprocal product
    // gives a quotient that is at most one short, so one conditional subtract finishes it.
    assign recip_prod = 64'(addr_reg) * 64'(RECIP);
    assign mr_fix     = (mr_reg >= 32'(MEM_DEPTH)) ? (mr_reg - 32'(MEM_DEPTH)) : mr_reg;

    rvmx_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (rf_raddr),
        .rdata (rf_rdata),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata)
    );

    rvmx_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (dm_busy),
        .we    (dm_we),
        .addr  (dm_addr),
        .wdata (dm_wdata),
        .rdata (dm_rdata)
    );

    rvmx_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A beat is taken only in the idle state and once the memory sweep has finished.
    assign req_stall = !((state_reg == S_IDLE) && !dm_busy);

    always_comb
    begin
        case (op_reg)
            OP_BEQ:  take = zf_reg;
            OP_BLT:  take = nf_reg;
            OP_BLE:  take = nf_reg || zf_reg;
            OP_BNE:  take = !zf_reg;
            OP_BGT:  take = !nf_reg && !zf_reg;
            OP_BGE:  take = !nf_reg || zf_reg;
            OP_BR:   take = 1'b1;
            default: take = 1'b0;
        endcase
    end

    // The status that the step reports: a running step may still leave the code space.
    assign fin_status = run_reg ? ((nip_reg >= 32'(CODE_DEPTH)) ? ST_BADIP : ST_RUN)
                                : code_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        rv_next        = rv_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        res_next       = res_reg;
        addr_next      = addr_reg;
        maddr_next     = maddr_reg;
        mq_next        = mq_reg;
        mr_next        = mr_reg;
        wa_next        = wa_reg;
        wb1_next       = wb1_reg;
        nip_next       = nip_reg;
        run_next       = run_reg;
        code_next      = code_reg;
        ov_next        = ov_reg;
        oval_next      = oval_reg;
        ip_next        = ip_reg;
        zf_next        = zf_reg;
        nf_next        = nf_reg;
        stopped_next   = stopped_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_ip_next    = rsp_ip_reg;
        rsp_ov_next    = rsp_ov_reg;
        rsp_oval_next  = rsp_oval_reg;
        rsp_st_next    = rsp_st_reg;

        rf_raddr    = rb;
        rf_we       = 1'b0;
        rf_waddr    = wa_reg;
        rf_wdata    = res_reg;
        dm_we       = 1'b0;
        dm_addr     = maddr_reg;
        dm_wdata    = va_reg;
        div_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    op_next   = req_type;
                    a_next    = field_a;
                    b_next    = field_b;
                    c_next    = field_c;
                    rv_next   = read_value;
                    nip_next  = ip_reg + 32'd1;
                    wb1_next  = 1'b0;
                    wa_next   = field_a[REG_AW-1:0];
                    ov_next   = 1'b0;
                    oval_next = 32'd0;
                    // A frozen block goes straight to the result state and changes nothing.
                    if (stopped_reg != ST_RUN)
                    begin
                        run_next   = 1'b0;
                        code_next  = stopped_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        run_next   = 1'b1;
                        code_next  = ST_RUN;
                        state_next = S_RB;
                    end
                end
            end
            S_RB:
            begin
                rf_raddr   = rb;
                state_next = S_RC;
            end
            S_RC:
            begin
                rf_raddr   = rc;
                vb_next    = (rb == IP_REG) ? ip_reg : rf_rdata;
                state_next = S_RA;
            end
            S_RA:
            begin
                rf_raddr   = ra;
                vc_next    = (rc == IP_REG) ? ip_reg : rf_rdata;
                state_next = S_CAPA;
            end
            S_CAPA:
            begin
                va_next    = (ra == IP_REG) ? ip_reg : rf_rdata;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_READ:
                    begin
                        res_next   = rv_reg;
                        wb1_next   = 1'b1;
                        state_next = S_WB1;
                    end
                    OP_WR:
                    begin
                        ov_next   = 1'b1;
                        oval_next = va_reg;
                    end
                    OP_BEQ, OP_BLT, OP_BLE, OP_BNE, OP_BGT, OP_BGE, OP_BR:
                    begin
                        if (take)
                        begin
                            nip_next = br_target;
                        end
                    end
                    OP_BL:
                    begin
                        res_next   = ip_reg + 32'd1;
                        wa_next    = LINK_REG;
                        wb1_next   = 1'b1;
                        nip_next   = br_target;
                        state_next = S_WB1;
                    end
                    OP_RET:
                    begin
                        nip_next = va_reg;
                    end
                    OP_MOV:
                    begin
                        res_next   = vb_reg;
                        wb1_next   = 1'b1;
                        state_next = S_WB1;
                    end
                    OP_CMP:
                    begin
                        zf_next = (va_reg == vb_reg);
                        nf_next = (va_reg < vb_reg);
                    end
                    OP_CMPI:
                    begin
                        zf_next = (va_reg == b_reg);
                        nf_next = (va_reg < b_reg);
                    end
                    OP_MOVI:
                    begin
                        res_next   = b_reg;
                        wb1_next   = 1'b1;
                        state_next = S_WB1;
                    end
                    OP_ADD, OP_ADDI:
                    begin
                        res_next   = vb_reg + y;
                        wb1_next   = 1'b1;
                        state_next = S_WB1;
                    end
                    OP_SUB, OP_SUBI:
                    begin
                        res_next   = vb_reg - y;
                        wb1_next   = 1'b1;
                        state_next = S_WB1;
                    end
                    OP_MUL, OP_MULI:
                    begin
                        res_next   = prod;
                        wb1_next   = 1'b1;
                        state_next = S_WB1;
                    end
                    OP_DIV, OP_MOD, OP_DIVI, OP_MODI:
                    begin
                        wb1_next = 1'b1;
                        if (y == 32'd0)
                        begin
                            res_next   = 32'd0;
                            state_next = S_WB1;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            div_req.num   = vb_reg;
                            div_req.den   = y;
                            state_next    = S_DIVW;
                        end
                    end
                    OP_LD, OP_ST:
                    begin
                        addr_next  = vb_reg + c_reg;
                        state_next = S_ADDR;
                    end
                    OP_PSH:
                    begin
                        addr_next  = vb_reg + 32'd1;
                        state_next = S_ADDR;
                    end
                    OP_POP:
                    begin
                        addr_next  = vb_reg;
                        state_next = S_ADDR;
                    end
                    OP_NOP:
                    begin
                        state_next = S_DONE;
                    end
                    OP_HLT:
                    begin
                        run_next  = 1'b0;
                        code_next = ST_HALT;
                    end
                    default:
                    begin
                        run_next  = 1'b0;
                        code_next = ST_BADOP;
                    end
                endcase
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    res_next   = ((op_reg == OP_DIV) || (op_reg == OP_DIVI)) ? div_rsp.quot
                                                                             : div_rsp.rem;
                    state_next = S_WB1;
                end
            end
            S_ADDR:
            begin
                if (POW2)
                begin
                    maddr_next = addr_reg[AW-1:0];
                    state_next = S_MEM;
                end
                else
                begin
                    mq_next    = recip_prod[63:32];
                    state_next = S_MODW;
                end
            end
            S_MODW:
            begin
                mr_next    = addr_reg - (mq_reg * 32'(MEM_DEPTH));
                state_next = S_MODR;
            end
            S_MODR:
            begin
                maddr_next = mr_fix[AW-1:0];
                state_next = S_MEM;
            end
            S_MEM:
            begin
                dm_addr = maddr_reg;
                case (op_reg)
                    OP_ST:
                    begin
                        dm_we      = 1'b1;
                        dm_wdata   = va_reg;
                        state_next = S_DONE;
                    end
                    OP_PSH:
                    begin
                        // The pointer is bumped first, so a push of the pointer stores it new.
                        dm_we      = 1'b1;
                        dm_wdata   = (ra == rb) ? addr_reg : va_reg;
                        state_next = S_WB2;
                    end
                    default:
                    begin
                        state_next = S_MWAIT;
                    end
                endcase
            end
            S_MWAIT:
            begin
                res_next   = dm_rdata;
                wb1_next   = 1'b1;
                state_next = S_WB1;
            end
            S_WB1:
            begin
                rf_we      = wb1_reg && (wa_reg != IP_REG);
                rf_waddr   = wa_reg;
                rf_wdata   = res_reg;
                state_next = (op_reg == OP_POP) ? S_WB2 : S_DONE;
            end
            S_WB2:
            begin
                rf_we    = (rb != IP_REG);
                rf_waddr = rb;
                if (op_reg == OP_POP)
                begin
                    // The pop decrements the pointer as the load just left it.
                    rf_wdata = (ra == rb) ? (res_reg - 32'd1) : (vb_reg - 32'd1);
                end
                else
                begin
                    rf_wdata = addr_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ip_next    = run_reg ? nip_reg : ip_reg;
                    rsp_ov_next    = ov_reg;
                    rsp_oval_next  = oval_reg;
                    rsp_st_next    = fin_status;
                    stopped_next   = fin_status;
                    if (run_reg)
                    begin
                        ip_next = nip_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ip_reg        <= 32'd0;
            zf_reg        <= 1'b0;
            nf_reg        <= 1'b0;
            stopped_reg   <= ST_RUN;
            rsp_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
            code_reg      <= ST_RUN;
            wb1_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ip_reg        <= ip_next;
            zf_reg        <= zf_next;
            nf_reg        <= nf_next;
            stopped_reg   <= stopped_next;
            rsp_valid_reg <= rsp_valid_next;
            run_reg       <= run_next;
            code_reg      <= code_next;
            wb1_reg       <= wb1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        rv_reg       <= rv_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        vc_reg       <= vc_next;
        res_reg      <= res_next;
        addr_reg     <= addr_next;
        maddr_reg    <= maddr_next;
        mq_reg       <= mq_next;
        mr_reg       <= mr_next;
        wa_reg       <= wa_next;
        nip_reg      <= nip_next;
        ov_reg       <= ov_next;
        oval_reg     <= oval_next;
        rsp_ip_reg   <= rsp_ip_next;
        rsp_ov_reg   <= rsp_ov_next;
        rsp_oval_reg <= rsp_oval_next;
        rsp_st_reg   <= rsp_st_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign next_ip   = rsp_ip_reg;
    assign out_valid = rsp_ov_reg;
    assign out_value = rsp_oval_reg;
    assign status    = rsp_st_reg;

    // Once stopped, the block stays stopped with the same code.
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg != ST_RUN) |=> (stopped_reg == $past(stopped_reg)))
        else $error("stopped code changed after the block froze");

    // Register 15 lives outside the register file and is never written there.
    a_no_ip_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (rf_waddr != IP_REG))
        else $error("register file write to the instruction pointer");

    // The divider is only started while it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // An emitted value never comes with a halt or bad opcode status.
    a_wr_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_valid) |-> ((status == ST_RUN) || (status == ST_BADIP)))
        else $error("write beat reported with a stop status");

    // No instruction is in flight during the clearing sweep, so no data memory write is issued.
    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        dm_busy |-> (state_reg == S_IDLE))
        else $error("instruction in flight during memory clearing");

endmodule

// ===== dv/register_vm_instruction_executor_unit_tb.sv =====
// Self-checking testbench for the register machine executor: directed programs, random programs and a final freeze.
module register_vm_instruction_executor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rvmx_pkg::*;

    // Memory depth of the instance; the predictor wraps addresses with the same figure.
    localparam int MEM_WORDS = 1024;
    // Branch targets stay below this mark so that straight-line code cannot run off the code space.
    localparam int IP_SAFE = CODE_DEPTH - 24;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 20000;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] next_ip;
        logic        out_valid;
        logic [31:0] out_value;
        logic [1:0]  status;
    } exec_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [4:0]         req_type = OP_NOP;
    logic signed [31:0] field_a = '0;
    logic signed [31:0] field_b = '0;
    logic signed [31:0] field_c = '0;
    logic [31:0]        read_value = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [31:0]        next_ip;
    logic               out_valid;
    logic [31:0]        out_value;
    logic [1:0]         status;

    // Shadow copy of the machine state, updated as each instruction beat is accepted.
    logic [31:0] shadow_regs [16];
    logic [31:0] shadow_mem [MEM_WORDS];
    logic        shadow_zf;
    logic        shadow_nf;
    logic [1:0]  shadow_stop;

    exec_result_t pending_results [$];
    int unsigned  error_count = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  rsp_idle_pct = 0;
    bit           hold_request = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  quiet_cycles = 0;

    register_vm_instruction_executor_unit #(
        .MEM_DEPTH (MEM_WORDS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .field_a    (field_a),
        .field_b    (field_b),
        .field_c    (field_c),
        .read_value (read_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .next_ip    (next_ip),
        .out_valid  (out_valid),
        .out_value  (out_value),
        .status     (status)
    );

    always #10 clk = ~clk;

    // Executes one instruction on the shadow state and queues the result that the block must give.
    task automatic execute_shadow(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] rv);
        logic [31:0]  ip;
        logic [31:0]  nxt;
        logic [31:0]  target;
        logic [3:0]   ra;
        logic [3:0]   rb;
        logic [3:0]   rc;
        logic         run;
        exec_result_t res;
        ip     = shadow_regs[IP_REG];
        nxt    = ip + 32'd1;
        target = ip + a;
        ra     = a[3:0];
        rb     = b[3:0];
        rc     = c[3:0];
        run    = 1'b1;
        res    = '0;
        if (shadow_stop != ST_RUN)
        begin
            // A frozen machine only repeats its IP and its stop code.
            res.next_ip = ip;
            res.status  = shadow_stop;
            pending_results.push_back(res);
            return;
        end
        case (op)
            OP_READ: shadow_regs[ra] = rv;
            OP_WR:
            begin
                res.out_valid = 1'b1;
                res.out_value = shadow_regs[ra];
            end
            OP_BEQ:  if (shadow_zf) nxt = target;
            OP_BLT:  if (shadow_nf) nxt = target;
            OP_BLE:  if (shadow_nf || shadow_zf) nxt = target;
            OP_BNE:  if (!shadow_zf) nxt = target;
            OP_BGT:  if (!shadow_nf && !shadow_zf) nxt = target;
            OP_BGE:  if (!shadow_nf || shadow_zf) nxt = target;
            OP_BR:   nxt = target;
            OP_BL:
            begin
                shadow_regs[LINK_REG] = ip + 32'd1;
                nxt = target;
            end
            OP_RET:  nxt = shadow_regs[ra];
            OP_MOV:  shadow_regs[ra] = shadow_regs[rb];
            OP_CMP:
            begin
                shadow_zf = (shadow_regs[ra] == shadow_regs[rb]);
                shadow_nf = (shadow_regs[ra] <  shadow_regs[rb]);
            end
            OP_ADD:  shadow_regs[ra] = shadow_regs[rb] + shadow_regs[rc];
            OP_SUB:  shadow_regs[ra] = shadow_regs[rb] - shadow_regs[rc];
            OP_MUL:  shadow_regs[ra] = shadow_regs[rb] * shadow_regs[rc];
            OP_DIV:  shadow_regs[ra] = (shadow_regs[rc] == 0) ? '0 :
                                       shadow_regs[rb] / shadow_regs[rc];
            OP_MOD:  shadow_regs[ra] = (shadow_regs[rc] == 0) ? '0 :
                                       shadow_regs[rb] % shadow_regs[rc];
            OP_MOVI: shadow_regs[ra] = b;
            OP_CMPI:
            begin
                shadow_zf = (shadow_regs[ra] == b);
                shadow_nf = (shadow_regs[ra] <  b);
            end
            OP_ADDI: shadow_regs[ra] = shadow_regs[rb] + c;
            OP_SUBI: shadow_regs[ra] = shadow_regs[rb] - c;
            OP_MULI: shadow_regs[ra] = shadow_regs[rb] * c;
            OP_DIVI: shadow_regs[ra] = (c == 0) ? '0 : shadow_regs[rb] / c;
            OP_MODI: shadow_regs[ra] = (c == 0) ? '0 : shadow_regs[rb] % c;
            OP_LD:   shadow_regs[ra] = shadow_mem[(shadow_regs[rb] + c) % MEM_WORDS];
            OP_ST:   shadow_mem[(shadow_regs[rb] + c) % MEM_WORDS] = shadow_regs[ra];
            OP_PSH:
            begin
                shadow_regs[rb] = shadow_regs[rb] + 32'd1;
                shadow_mem[shadow_regs[rb] % MEM_WORDS] = shadow_regs[ra];
            end
            OP_POP:
            begin
                shadow_regs[ra] = shadow_mem[shadow_regs[rb] % MEM_WORDS];
                shadow_regs[rb] = shadow_regs[rb] - 32'd1;
            end
            OP_NOP: ;
            OP_HLT:
            begin
                shadow_stop = ST_HALT;
                run = 1'b0;
            end
            default:
            begin
                shadow_stop = ST_BADOP;
                run = 1'b0;
            end
        endcase
        if (run)
        begin
            // The IP register always ends up with the next IP, whatever was written to it.
            shadow_regs[IP_REG] = nxt;
            if (nxt >= CODE_DEPTH)
                shadow_stop = ST_BADIP;
        end
        res.next_ip = shadow_regs[IP_REG];
        res.status  = shadow_stop;
        pending_results.push_back(res);
    endtask

    // Offers one instruction beat, with a random gap in front of it, and waits until it is taken.
    task automatic send_instr(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] rv);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= op;
        field_a    <= a;
        field_b    <= b;
        field_c    <= c;
        read_value <= rv;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        execute_shadow(op, a, b, c, rv);
    endtask

    // Operand value biased towards the corners of the 32-bit range.
    function automatic logic [31:0] corner_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4, 5: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    // Builds one random instruction that keeps the machine running, then sends it.
    task automatic send_random_instr();
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] ip;
        logic        taken;
        op = 5'($urandom_range(OP_NOP));
        a  = corner_word();
        b  = corner_word();
        c  = corner_word();
        ip = shadow_regs[IP_REG];
        // On a coin toss, register index fields get random upper bits; only the low nibble selects.
        if ($urandom_range(1))
        begin
            a = {28'($urandom), a[3:0]};
            b = {28'($urandom), b[3:0]};
            c = {28'($urandom), c[3:0]};
        end
        if (ip >= IP_SAFE)
        begin
            // Close to the end of the code space: jump back before straight-line code overruns it.
            op = OP_BR;
            a  = $urandom_range(IP_SAFE - 1) - ip;
        end
        else if (op >= OP_BEQ && op <= OP_BL)
        begin
            case (op)
                OP_BEQ:  taken = shadow_zf;
                OP_BLT:  taken = shadow_nf;
                OP_BLE:  taken = shadow_nf || shadow_zf;
                OP_BNE:  taken = !shadow_zf;
                OP_BGT:  taken = !shadow_nf && !shadow_zf;
                OP_BGE:  taken = !shadow_nf || shadow_zf;
                default: taken = 1'b1;
            endcase
            // An untaken branch may carry any offset; a taken one must land inside the code.
            if (taken)
                a = $urandom_range(IP_SAFE - 1) - ip;
        end
        else if (op == OP_RET && shadow_regs[a[3:0]] >= IP_SAFE)
        begin
            // The return address is out of reach, so load a usable one instead.
            op = OP_MOVI;
            b  = $urandom_range(IP_SAFE - 1);
        end
        send_instr(op, a, b, c, $urandom);
    endtask

    // Waits until every queued result has been returned by the block.
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register moves, arithmetic, compares and branches with extreme operands and wrapped indexes.
    task automatic test_alu_and_branches();
        send_instr(OP_READ, 32'h0000_0001, '0, '0, 32'hFFFF_FFFF);
        send_instr(OP_READ, 32'hFFFF_FFF2, '0, '0, 32'h0000_0000);
        send_instr(OP_READ, 32'h0000_0003, '0, '0, 32'h8000_0000);
        send_instr(OP_MOVI, 32'h0000_0004, 32'h7FFF_FFFF, '0, '0);
        send_instr(OP_ADD,  32'd6, 32'd1, 32'd3, '0);
        send_instr(OP_SUB,  32'd7, 32'd2, 32'd1, '0);
        send_instr(OP_MUL,  32'd8, 32'd1, 32'd3, '0);
        send_instr(OP_DIV,  32'd9, 32'd1, 32'd4, '0);
        // Division and modulo by zero give zero.
        send_instr(OP_DIV,  32'd10, 32'd1, 32'd2, '0);
        send_instr(OP_MODI, 32'd11, 32'd1, 32'd0, '0);
        send_instr(OP_DIVI, 32'd12, 32'd1, 32'h8000_0000, '0);
        // Reading the IP register yields the address of the current instruction.
        send_instr(OP_SUBI, 32'd13, 32'd15, 32'hFFFF_FFFF, '0);
        // A write to the IP register is overwritten by the next IP.
        send_instr(OP_MOV,  32'd15, 32'd1, '0, '0);
        send_instr(OP_CMP,  32'd2, 32'd1, '0, '0);
        send_instr(OP_BLT,  32'd3, '0, '0, '0);
        send_instr(OP_CMPI, 32'd2, 32'd0, '0, '0);
        send_instr(OP_BNE,  32'hFFFF_FFF0, '0, '0, '0);
        send_instr(OP_BEQ,  32'd2, '0, '0, '0);
        send_instr(OP_WR,   32'h7FFF_FFF1, '0, '0, '0);
        send_instr(OP_BL,   32'd5, '0, '0, '0);
        send_instr(OP_RET,  32'd14, '0, '0, '0);
        send_instr(OP_NOP,  '0, '0, '0, '0);
    endtask

    // Loads and stores with wrapping addresses, and push and pop on the same register.
    task automatic test_memory();
        send_instr(OP_ST,  32'd1, 32'd2, 32'hFFFF_FFFF, '0);
        send_instr(OP_LD,  32'd5, 32'd3, 32'h7FFF_FFFF, '0);
        send_instr(OP_PSH, 32'd2, 32'd2, '0, '0);
        send_instr(OP_POP, 32'd2, 32'd2, '0, '0);
        send_instr(OP_WR,  32'd2, '0, '0, '0);
    endtask

    // One random phase with the given sender and receiver idling.
    task automatic test_random(input int unsigned count, input int unsigned send_pct,
                               input int unsigned rsp_pct);
        send_idle_pct = send_pct;
        rsp_idle_pct  = rsp_pct;
        repeat (count)
            send_random_instr();
    endtask

    // The receiver holds off while beats keep coming, then the sender waits for a full drain.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        hold_request  = 1'b1;
        repeat (40)
            send_random_instr();
        req_valid <= 1'b0;
        @(posedge clk);
        drain_results();
    endtask

    // Freezes the machine in one of its three ways, then checks that it stays frozen.
    task automatic test_freeze();
        logic [31:0] ip;
        send_idle_pct = 20;
        rsp_idle_pct  = 20;
        ip = shadow_regs[IP_REG];
        case ($urandom_range(2))
            0: send_instr(OP_HLT, $urandom, $urandom, $urandom, $urandom);
            1: send_instr(5'd31, $urandom, $urandom, $urandom, $urandom);
            default: send_instr(OP_BR, CODE_DEPTH + $urandom_range(1000) - ip, '0, '0, '0);
        endcase
        repeat (6)
            send_instr(5'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    // Result checking and receiver stall, both on the pre-edge values of the outputs.
    always @(posedge clk)
    begin
        exec_result_t exp_res;
        if (rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: next_ip %h", next_ip);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (next_ip !== exp_res.next_ip)
                begin
                    $error("next_ip: expected %h, got %h", exp_res.next_ip, next_ip);
                    error_count++;
                end
                if (out_valid !== exp_res.out_valid)
                begin
                    $error("out_valid: expected %h, got %h", exp_res.out_valid, out_valid);
                    error_count++;
                end
                if (out_value !== exp_res.out_value)
                begin
                    $error("out_value: expected %h, got %h", exp_res.out_value, out_value);
                    error_count++;
                end
                if (status !== exp_res.status)
                begin
                    $error("status: expected %h, got %h", exp_res.status, status);
                    error_count++;
                end
            end
        end
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("register_vm_instruction_executor_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        foreach (shadow_mem[i])
            shadow_mem[i] = '0;
        shadow_zf   = 1'b0;
        shadow_nf   = 1'b0;
        shadow_stop = ST_RUN;

        // Reset once; the memory clearing pass afterwards simply stalls the first beat.
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alu_and_branches();
        test_memory();
        test_random(450, 0, 0);
        test_random(450, 59, 0);
        test_back_pressure();
        test_random(450, 0, 59);
        test_random(450, 33, 33);
        test_freeze();

        req_valid <= 1'b0;
        @(posedge clk);
        drain_results();
        repeat (60)
            @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("register_vm_instruction_executor_unit_tb: done, clean");
        else
            $display("register_vm_instruction_executor_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rvmx_pkg.sv
rtl/rvmx_regfile.sv
rtl/rvmx_dmem.sv
rtl/rvmx_divider.sv
rtl/register_vm_instruction_executor_unit.sv
dv/register_vm_instruction_executor_unit_tb.sv
